/* hdl/tmq_pkg.sv */
// Shared types and constants of the deadline-sorted timer queue.
package tmq_pkg;

  localparam int NUM_HANDLES = 64;
  localparam int HANDLE_W    = 6;
  localparam int IN_TIME_W   = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [HANDLE_W-1:0]    handle;
    logic [IN_TIME_W-1:0]   deadline;
    logic [IN_TIME_W-1:0]   now_time;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic                   expired_valid;
    logic [HANDLE_W-1:0]    expired_handle;
    logic                   last;
  } out_t;

endpackage

/* hdl/tmq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tmq_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tmq_ctrl.sv */
// Sequencer of the timer queue: walks the ordered list through its deadline compares.
module tmq_ctrl
  import tmq_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 32,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_o,
  output logic                 list_we_o,
  output logic [IW-1:0]        list_waddr_o,
  output logic [HANDLE_W-1:0]  list_wdata_o,
  output logic [IW-1:0]        list_raddr_o,
  input  logic [HANDLE_W-1:0]  list_rdata_i,
  output logic                 dl_we_o,
  output logic [HANDLE_W-1:0]  dl_waddr_o,
  output logic [TIME_BITS-1:0] dl_wdata_o,
  output logic [HANDLE_W-1:0]  dl_raddr_o,
  input  logic [TIME_BITS-1:0] dl_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INS_RD, S_INS_NB, S_INS_CMP, S_RM_RD, S_RM_CHK,
    S_TK_RD, S_TK_NB, S_TK_CMP, S_OUT
  } state_e;

  state_e                 state_q;
  cmd_e                   cmd_q;
  logic [HANDLE_W-1:0]    hdl_q;
  logic [TIME_BITS-1:0]   dl_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [IW-1:0]          head_q;
  logic [CW-1:0]          cnt_q;
  logic [CW-1:0]          idx_q;
  logic                   found_q;
  logic [HANDLE_W-1:0]    nb_q;
  logic [HANDLE_W-1:0]    pend_q;
  logic                   pend_vld_q;
  logic [NUM_HANDLES-1:0] active_q;
  out_t                   out_q;
  logic                   out_vld_q;
  logic                   ret_idle_q;

  // Map a list offset onto the circular buffer.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                         input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  logic [CW-1:0] idx_m1;
  logic          later;
  logic          expired;

  assign idx_m1  = idx_q - CW'(1);
  assign later   = dl_rdata_i > dl_q;
  assign expired = now_q >= dl_rdata_i;

  always_comb begin
    list_we_o    = 1'b0;
    list_waddr_o = '0;
    list_wdata_o = '0;
    list_raddr_o = '0;
    dl_we_o      = 1'b0;
    dl_waddr_o   = hdl_q;
    dl_wdata_o   = dl_q;
    dl_raddr_o   = '0;
    case (state_q)
      S_DECODE: begin
        dl_we_o = (cmd_q == CMD_ADD) && !active_q[hdl_q] && (cnt_q != CW'(DEPTH));
      end
      S_INS_RD: begin
        if (idx_q == '0) begin
          list_we_o    = 1'b1;
          list_waddr_o = head_q;
          list_wdata_o = hdl_q;
        end else begin
          list_raddr_o = phys(head_q, IW'(idx_m1));
        end
      end
      S_INS_NB: dl_raddr_o = list_rdata_i;
      S_INS_CMP: begin
        // Shift the neighbor up, or drop the new handle into the gap.
        list_we_o    = 1'b1;
        list_waddr_o = phys(head_q, IW'(idx_q));
        list_wdata_o = later ? nb_q : hdl_q;
      end
      S_RM_RD: begin
        if (idx_q != cnt_q) begin
          list_raddr_o = phys(head_q, IW'(idx_q));
        end else begin
          dl_we_o = (cmd_q == CMD_ADJUST);
        end
      end
      S_RM_CHK: begin
        if (found_q) begin
          list_we_o    = 1'b1;
          list_waddr_o = phys(head_q, IW'(idx_m1));
          list_wdata_o = list_rdata_i;
        end
      end
      S_TK_RD: list_raddr_o = head_q;
      S_TK_NB: dl_raddr_o   = list_rdata_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      active_q   <= '0;
      out_vld_q  <= 1'b0;
      ret_idle_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= in_i.cmd;
            hdl_q   <= in_i.handle;
            dl_q    <= TIME_BITS'(in_i.deadline);
            now_q   <= TIME_BITS'(in_i.now_time);
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (cmd_q)
            CMD_ADD: begin
              if (active_q[hdl_q] || cnt_q == CW'(DEPTH)) begin
                out_q      <= '{active_q[hdl_q] ? ST_DUPLICATE : ST_FULL, 1'b0, '0, 1'b1};
                out_vld_q  <= 1'b1;
                ret_idle_q <= 1'b1;
                state_q    <= S_OUT;
              end else begin
                active_q[hdl_q] <= 1'b1;
                idx_q           <= cnt_q;
                state_q         <= S_INS_RD;
              end
            end
            CMD_ADJUST, CMD_DELETE: begin
              if (!active_q[hdl_q]) begin
                out_q      <= '{ST_NOT_FOUND, 1'b0, '0, 1'b1};
                out_vld_q  <= 1'b1;
                ret_idle_q <= 1'b1;
                state_q    <= S_OUT;
              end else begin
                idx_q   <= '0;
                found_q <= 1'b0;
                state_q <= S_RM_RD;
              end
            end
            default: begin
              pend_vld_q <= 1'b0;
              state_q    <= S_TK_RD;
            end
          endcase
        end
        S_INS_RD: begin
          if (idx_q == '0) begin
            cnt_q      <= cnt_q + CW'(1);
            out_q      <= '{ST_OK, 1'b0, '0, 1'b1};
            out_vld_q  <= 1'b1;
            ret_idle_q <= 1'b1;
            state_q    <= S_OUT;
          end else begin
            state_q <= S_INS_NB;
          end
        end
        S_INS_NB: begin
          nb_q    <= list_rdata_i;
          state_q <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (later) begin
            idx_q   <= idx_m1;
            state_q <= S_INS_RD;
          end else begin
            cnt_q      <= cnt_q + CW'(1);
            out_q      <= '{ST_OK, 1'b0, '0, 1'b1};
            out_vld_q  <= 1'b1;
            ret_idle_q <= 1'b1;
            state_q    <= S_OUT;
          end
        end
        S_RM_RD: begin
          if (idx_q == cnt_q) begin
            cnt_q <= cnt_q - CW'(1);
            if (cmd_q == CMD_ADJUST) begin
              idx_q   <= cnt_q - CW'(1);
              state_q <= S_INS_RD;
            end else begin
              active_q[hdl_q] <= 1'b0;
              out_q           <= '{ST_OK, 1'b0, '0, 1'b1};
              out_vld_q       <= 1'b1;
              ret_idle_q      <= 1'b1;
              state_q         <= S_OUT;
            end
          end else begin
            state_q <= S_RM_CHK;
          end
        end
        S_RM_CHK: begin
          if (list_rdata_i == hdl_q) begin
            found_q <= 1'b1;
          end
          idx_q   <= idx_q + CW'(1);
          state_q <= S_RM_RD;
        end
        S_TK_RD: begin
          if (cnt_q == '0) begin
            out_q      <= pend_vld_q ? out_t'{ST_OK, 1'b1, pend_q, 1'b1}
                                     : out_t'{ST_OK, 1'b0, '0, 1'b1};
            out_vld_q  <= 1'b1;
            ret_idle_q <= 1'b1;
            state_q    <= S_OUT;
          end else begin
            state_q <= S_TK_NB;
          end
        end
        S_TK_NB: begin
          nb_q    <= list_rdata_i;
          state_q <= S_TK_CMP;
        end
        S_TK_CMP: begin
          if (expired) begin
            // Pop the head; hold it until the next check tells whether it is last.
            head_q         <= phys(head_q, IW'(1));
            cnt_q          <= cnt_q - CW'(1);
            active_q[nb_q] <= 1'b0;
            pend_q         <= nb_q;
            pend_vld_q     <= 1'b1;
            if (pend_vld_q) begin
              out_q      <= '{ST_OK, 1'b1, pend_q, 1'b0};
              out_vld_q  <= 1'b1;
              ret_idle_q <= 1'b0;
              state_q    <= S_OUT;
            end else begin
              state_q <= S_TK_RD;
            end
          end else begin
            out_q      <= pend_vld_q ? out_t'{ST_OK, 1'b1, pend_q, 1'b1}
                                     : out_t'{ST_OK, 1'b0, '0, 1'b1};
            out_vld_q  <= 1'b1;
            ret_idle_q <= 1'b1;
            state_q    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_vld_q <= 1'b0;
            state_q   <= ret_idle_q ? S_IDLE : S_TK_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

/* hdl/deadline_sorted_timer_queue.sv */
// Top level of the deadline-sorted timer queue.
// Holds up to DEPTH timers keyed by a 6-bit handle, kept in deadline order.
// Input channel (in_valid_i / in_stall_o / in_i): one transaction carries a
// command (add, adjust, delete, tick) with handle, deadline and current time.
// Output channel (out_valid_o / out_stall_i / out_o): add, adjust and delete
// give one transaction; tick gives one per expired timer, the last flagged,
// or a single empty one when nothing expired.
// One command at a time: in_stall_o is high from acceptance until its final
// result is taken. The list lives in a circular RAM walked by one sequencer
// with two deadline compares.
// Add walks from the tail toward the front, shifting each later timer up a place;
// delete scans the whole list, closing the gap; adjust removes the timer the same
// way and then adds it anew over the remaining timers. Tick checks timers from the
// head, popping each one that has expired.
// The sequencer waits in place while out_stall_i is high; no result is lost.
// Reset clears the timer count, the list head and all active flags at once;
// the RAM contents need no clearing.
module deadline_sorted_timer_queue
  import tmq_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int IW = $clog2(DEPTH);

  logic                 list_we;
  logic [IW-1:0]        list_waddr;
  logic [HANDLE_W-1:0]  list_wdata;
  logic [IW-1:0]        list_raddr;
  logic [HANDLE_W-1:0]  list_rdata;
  logic                 dl_we;
  logic [HANDLE_W-1:0]  dl_waddr;
  logic [TIME_BITS-1:0] dl_wdata;
  logic [HANDLE_W-1:0]  dl_raddr;
  logic [TIME_BITS-1:0] dl_rdata;

  tmq_ctrl #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_i,
    .out_valid_o,
    .out_stall_i,
    .out_o,
    .list_we_o    (list_we),
    .list_waddr_o (list_waddr),
    .list_wdata_o (list_wdata),
    .list_raddr_o (list_raddr),
    .list_rdata_i (list_rdata),
    .dl_we_o      (dl_we),
    .dl_waddr_o   (dl_waddr),
    .dl_wdata_o   (dl_wdata),
    .dl_raddr_o   (dl_raddr),
    .dl_rdata_i   (dl_rdata)
  );

  tmq_ram #(.W(HANDLE_W), .D(DEPTH)) u_list_ram (
    .clk_i,
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  tmq_ram #(.W(TIME_BITS), .D(NUM_HANDLES)) u_dl_ram (
    .clk_i,
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (dl_raddr),
    .rdata_o (dl_rdata)
  );

`ifndef SYNTH
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.expired_valid) |-> out_o.last)
    else $error("result without expired handle not flagged last");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != ST_OK) |-> (out_o.last && !out_o.expired_valid))
    else $error("error result carries an expired handle");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sequencer not busy after accepting a command");
`endif

endmodule

/* tb/sv/tb_deadline_sorted_timer_queue.sv */
// Self-checking testbench for the deadline-sorted timer queue.
`timescale 1ns / 1ps

module tb_deadline_sorted_timer_queue;
  import tmq_pkg::*;

  localparam int DEPTH = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  deadline_sorted_timer_queue #(.DEPTH(DEPTH), .TIME_BITS(32)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow timer state
  logic [31:0] timer_deadline [NUM_HANDLES];
  logic        timer_active [NUM_HANDLES];
  logic [5:0]  timer_order [$];

  in_t  pending_cmds [$];
  out_t expected_results [$];
  int   error_count = 0;
  bit   drain_req = 1'b0;

  task automatic order_insert(input logic [5:0] h);
    int pos;
    pos = 0;
    while (pos < timer_order.size() && timer_deadline[timer_order[pos]] <= timer_deadline[h])
      pos++;
    timer_order.insert(pos, h);
  endtask

  task automatic order_remove(input logic [5:0] h);
    for (int i = 0; i < timer_order.size(); i++) begin
      if (timer_order[i] == h) begin
        timer_order.delete(i);
        break;
      end
    end
  endtask

  function automatic out_t make_result(status_e st, logic v, logic [5:0] h, logic l);
    out_t r;
    r.status = st;
    r.expired_valid = v;
    r.expired_handle = h;
    r.last = l;
    return r;
  endfunction

  task automatic predict_queue(input in_t c);
    int n;
    logic [5:0] first;
    n = 0;
    case (c.cmd)
      CMD_ADD: begin
        if (timer_active[c.handle]) begin
          expected_results.push_back(make_result(ST_DUPLICATE, 1'b0, '0, 1'b1));
        end else if (timer_order.size() >= DEPTH) begin
          expected_results.push_back(make_result(ST_FULL, 1'b0, '0, 1'b1));
        end else begin
          timer_deadline[c.handle] = c.deadline;
          timer_active[c.handle] = 1'b1;
          order_insert(c.handle);
          expected_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b1));
        end
      end
      CMD_ADJUST, CMD_DELETE: begin
        if (!timer_active[c.handle]) begin
          expected_results.push_back(make_result(ST_NOT_FOUND, 1'b0, '0, 1'b1));
        end else begin
          order_remove(c.handle);
          if (c.cmd == CMD_ADJUST) begin
            timer_deadline[c.handle] = c.deadline;
            order_insert(c.handle);
          end else begin
            timer_active[c.handle] = 1'b0;
          end
          expected_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b1));
        end
      end
      default: begin
        while (timer_order.size() > 0 && c.now_time >= timer_deadline[timer_order[0]]) begin
          first = timer_order.pop_front();
          timer_active[first] = 1'b0;
          expected_results.push_back(make_result(ST_OK, 1'b1, first, 1'b0));
          n++;
        end
        if (n == 0)
          expected_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b1));
        else
          expected_results[$].last = 1'b1;
      end
    endcase
  endtask

  task automatic push_cmd(cmd_e c, logic [5:0] h, logic [31:0] d, logic [31:0] t);
    in_t x;
    x.cmd = c;
    x.handle = h;
    x.deadline = d;
    x.now_time = t;
    pending_cmds.push_back(x);
  endtask

  // Driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_queue(in_i);
        send_gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
        if (pending_cmds.size() > 0 && send_gap == 0 && !drain_req) begin
          in_i <= pending_cmds.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i && pending_cmds.size() > 0) begin
        if (drain_req && expected_results.size() == 0) drain_req = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (!drain_req) begin
          in_i <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor
  int recv_gap = 0;
  out_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_o);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_o.status !== exp_r.status)
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_o.status);
          if (out_o.expired_valid !== exp_r.expired_valid)
            $display("%0t: expired_valid expected %0d actual %0d", $time,
                     exp_r.expired_valid, out_o.expired_valid);
          if (out_o.expired_handle !== exp_r.expired_handle)
            $display("%0t: expired_handle expected %0d actual %0d", $time,
                     exp_r.expired_handle, out_o.expired_handle);
          if (out_o.last !== exp_r.last)
            $display("%0t: last expected %0d actual %0d", $time, exp_r.last, out_o.last);
          if (out_o !== exp_r) error_count++;
        end
        recv_gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[deadline_sorted_timer_queue] ERROR");
    $finish;
  end

  initial begin
    logic [31:0] base;
    int r;
    for (int i = 0; i < NUM_HANDLES; i++) begin
      timer_active[i] = 1'b0;
      timer_deadline[i] = '0;
    end
    // Directed: errors, equal deadlines, earlier adjust, full table, extremes
    push_cmd(CMD_TICK, 6'd0, '0, '0);
    push_cmd(CMD_DELETE, 6'd5, '0, '0);
    push_cmd(CMD_ADJUST, 6'd63, 32'hFFFF_FFFF, '0);
    push_cmd(CMD_ADD, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(CMD_ADD, 6'd63, 32'd1, '0);
    push_cmd(CMD_ADD, 6'd1, 32'd10, '0);
    push_cmd(CMD_ADD, 6'd2, 32'd10, '0);
    push_cmd(CMD_ADD, 6'd0, 32'd0, '0);
    push_cmd(CMD_ADJUST, 6'd1, 32'd10, '0);
    push_cmd(CMD_ADJUST, 6'd63, 32'd5, '0);
    push_cmd(CMD_DELETE, 6'd2, '0, '0);
    push_cmd(CMD_TICK, '0, '0, 32'd9);
    push_cmd(CMD_TICK, '0, '0, 32'hFFFF_FFFF);
    for (int h = 0; h < NUM_HANDLES; h++) push_cmd(CMD_ADD, h[5:0], 32'd100, '0);
    push_cmd(CMD_ADD, 6'd7, 32'd1, '0);
    push_cmd(CMD_TICK, '0, '0, 32'd100);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0 && !in_valid_i);
    drain_req = 1'b1;
    // Random: adds and adjusts around a moving clock, with deletes, ticks and noise
    base = $urandom_range(0, 1000);
    for (int i = 0; i < 400; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        push_cmd(CMD_ADD, 6'($urandom_range(0, 23)), base + $urandom_range(0, 60), $urandom);
      else if (r < 55)
        push_cmd(CMD_ADJUST, 6'($urandom_range(0, 23)), base + $urandom_range(0, 60),
                 $urandom);
      else if (r < 65)
        push_cmd(CMD_DELETE, 6'($urandom_range(0, 23)), $urandom, $urandom);
      else if (r < 90) begin
        base = base + $urandom_range(0, 20);
        push_cmd(CMD_TICK, 6'($urandom), $urandom, base);
      end else
        push_cmd(cmd_e'($urandom_range(0, 3)), 6'($urandom), $urandom, $urandom);
    end
    push_cmd(CMD_TICK, '0, '0, 32'hFFFF_FFFF);
    // Wait for the last transaction to be taken and all its results to drain
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || in_stall_o ||
           expected_results.size() != 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0)
      $display("[deadline_sorted_timer_queue] OK");
    else
      $display("[deadline_sorted_timer_queue] ERROR");
    $finish;
  end

endmodule
